@@ rtl/core/assert_macros.svh @@
// ----------------------------------------------------------------------------
// assert_macros.svh
// Shared concurrent assertion macros for the wait queue RTL.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted (active low)
`define PWQ_ASSERT_IMPLY(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled while reset is asserted (active low)
`define PWQ_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
    else $error(msg);

`endif

@@ rtl/core/pwq_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pwq_pkg
// Types, constants and helpers for the priority wait queue resource grant.
// ----------------------------------------------------------------------------
package pwq_pkg;

  // Queue storage depth
  localparam int QUEUE_DEPTH = 32;
  localparam int IDX_W       = $clog2(QUEUE_DEPTH);
  localparam int CNT_W       = $clog2(QUEUE_DEPTH + 1);

  // Fixed payload widths
  localparam int REQ_W  = 2;
  localparam int ID_W   = 12;
  localparam int PRIO_W = 8;
  localparam int WAIT_W = 6;

  // Request type codes
  localparam logic [REQ_W-1:0] REQ_JOB      = 2'd0;
  localparam logic [REQ_W-1:0] REQ_DISPATCH = 2'd1;
  localparam logic [REQ_W-1:0] REQ_DEREG    = 2'd2;

  // One queue entry as stored in the RAM
  typedef struct packed {
    logic [ID_W-1:0]   id;
    logic [PRIO_W-1:0] prio;
  } pwq_entry_t;

  localparam int ENTRY_W = $bits(pwq_entry_t);

  // RAM access from the controller
  typedef struct packed {
    logic             we;
    logic [IDX_W-1:0] waddr;
    pwq_entry_t       wdata;
    logic [IDX_W-1:0] raddr;
  } pwq_mem_req_t;

  // One result item
  typedef struct packed {
    logic              granted_valid;
    logic [ID_W-1:0]   granted_id;
    logic              queue_was_empty;
    logic              job_terminated;
    logic              request_dropped;
    logic              resource_busy_now;
    logic [WAIT_W-1:0] waiting_count;
  } pwq_result_t;

  // Logical queue position to physical RAM slot (circular buffer)
  function automatic logic [IDX_W-1:0] pwq_phys(input logic [IDX_W-1:0] base,
                                                input logic [IDX_W-1:0] offs);
    logic [IDX_W:0] sum;
    sum = {1'b0, base} + {1'b0, offs};
    if (sum >= (IDX_W+1)'(QUEUE_DEPTH)) begin
      sum = sum - (IDX_W+1)'(QUEUE_DEPTH);
    end
    return sum[IDX_W-1:0];
  endfunction

endpackage

@@ rtl/core/priority_wait_queue_resource_grant.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// priority_wait_queue_resource_grant
// Single shared resource guarded by a priority-sorted wait queue held in RAM.
// ----------------------------------------------------------------------------
//   channel  | ports                                 | transfer
//   ---------+---------------------------------------+--------------------------
//   request  | start, busy, in_req_type/task_id/prio | start && !busy at clk
//   result   | out_valid, out_*                      | out_valid, one cycle
//
// Dispatch reads the head from the entry RAM and answers from S_POP.
// Deregister, full, empty, termination and unused-code requests, and a
// job into an empty queue, are answered straight from S_IDLE. Queuing a
// job behind other entries walks from the tail toward its slot, one RAM
// read-and-shift per cycle. The result is registered and shows in the
// cycle after the last step; a new request may be taken in that same
// cycle. Reset is synchronous, active low, and empties the queue at once.
// The receiver cannot stall the result.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module priority_wait_queue_resource_grant (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       start,
  output logic                       busy,
  input  logic [pwq_pkg::REQ_W-1:0]  in_req_type,
  input  logic [pwq_pkg::ID_W-1:0]   in_task_id,
  input  logic [pwq_pkg::PRIO_W-1:0] in_priority_req,
  output logic                       out_valid,
  output logic                       out_granted_valid,
  output logic [pwq_pkg::ID_W-1:0]   out_granted_id,
  output logic                       out_queue_was_empty,
  output logic                       out_job_terminated,
  output logic                       out_request_dropped,
  output logic                       out_resource_busy_now,
  output logic [pwq_pkg::WAIT_W-1:0] out_waiting_count
);

  import pwq_pkg::*;

  pwq_mem_req_t mem_req;
  pwq_entry_t   mem_rdata;
  logic         res_valid;
  pwq_result_t  res;
  logic         out_valid_r;
  pwq_result_t  res_r;

  // Sequencer
  pwq_ctrl u_ctrl (
    .clk          (clk),
    .rst_n        (rst_n),
    .start        (start),
    .req_type     (in_req_type),
    .task_id      (in_task_id),
    .priority_req (in_priority_req),
    .busy         (busy),
    .mem_req      (mem_req),
    .mem_rdata    (mem_rdata),
    .res_valid    (res_valid),
    .res          (res)
  );

  // Queue entry storage
  pwq_ram #(
    .WIDTH (ENTRY_W),
    .DEPTH (QUEUE_DEPTH)
  ) u_ram (
    .clk   (clk),
    .we    (mem_req.we),
    .waddr (mem_req.waddr),
    .wdata (mem_req.wdata),
    .raddr (mem_req.raddr),
    .rdata (mem_rdata)
  );

  // Result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= res_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (res_valid) begin
      res_r <= res;
    end
  end

  assign out_valid             = out_valid_r;
  assign out_granted_valid     = res_r.granted_valid;
  assign out_granted_id        = res_r.granted_id;
  assign out_queue_was_empty   = res_r.queue_was_empty;
  assign out_job_terminated    = res_r.job_terminated;
  assign out_request_dropped   = res_r.request_dropped;
  assign out_resource_busy_now = res_r.resource_busy_now;
  assign out_waiting_count     = res_r.waiting_count;

  // Checks
  `PWQ_ASSERT_NEXT(a_accept_progress, clk, rst_n,
    start && !busy, out_valid || busy,
    "accepted request neither answered nor in progress")
  `PWQ_ASSERT_IMPLY(a_grant_busy, clk, rst_n,
    out_valid && out_granted_valid, out_resource_busy_now && !out_queue_was_empty,
    "grant without busy resource")
  `PWQ_ASSERT_IMPLY(a_term_idle, clk, rst_n,
    out_valid && out_job_terminated, !out_resource_busy_now && !out_granted_valid,
    "termination left resource busy")

endmodule

@@ rtl/core/pwq_ram.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pwq_ram
// Generic simple dual-port RAM: one write port, one read port, registered read.
// ----------------------------------------------------------------------------
module pwq_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  // Write port and registered read port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_r <= mem[raddr];
  end

  assign rdata = rdata_r;

endmodule

@@ rtl/core/pwq_ctrl.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pwq_ctrl
// Request sequencer: grant state, circular queue pointers and the backward
// insertion walk over the entry RAM.
// ----------------------------------------------------------------------------
module pwq_ctrl (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         start,
  input  logic [pwq_pkg::REQ_W-1:0]    req_type,
  input  logic [pwq_pkg::ID_W-1:0]     task_id,
  input  logic [pwq_pkg::PRIO_W-1:0]   priority_req,
  output logic                         busy,
  output pwq_pkg::pwq_mem_req_t        mem_req,
  input  pwq_pkg::pwq_entry_t          mem_rdata,
  output logic                         res_valid,
  output pwq_pkg::pwq_result_t         res
);

  import pwq_pkg::*;

  typedef enum logic [3:0] {
    S_IDLE = 4'b0001,
    S_WALK = 4'b0010,
    S_LAST = 4'b0100,
    S_POP  = 4'b1000
  } pwq_state_t;

  pwq_state_t        state_r, state_nxt;
  logic [CNT_W-1:0]  fill_r, fill_nxt;
  logic [IDX_W-1:0]  head_r, head_nxt;
  logic [IDX_W-1:0]  cur_r, cur_nxt;
  logic              rbusy_r, rbusy_nxt;
  logic [ID_W-1:0]   owner_r, owner_nxt;
  pwq_entry_t        new_r, new_nxt;
  logic              move;

  assign busy = (state_r != S_IDLE);

  // Walk step: does the entry under the cursor shift up one slot?
  always_comb begin
    if (cur_r != '0) begin
      move = (mem_rdata.prio >= new_r.prio);
    end else begin
      move = (mem_rdata.prio > new_r.prio);
    end
  end

  // Next-state and RAM access
  always_comb begin
    state_nxt = state_r;
    fill_nxt  = fill_r;
    head_nxt  = head_r;
    cur_nxt   = cur_r;
    rbusy_nxt = rbusy_r;
    owner_nxt = owner_r;
    new_nxt   = new_r;
    mem_req   = '0;
    res_valid = 1'b0;
    res       = '0;

    unique case (state_r)
      S_IDLE: begin
        mem_req.raddr = head_r;
        if (start) begin
          new_nxt.id   = task_id;
          new_nxt.prio = priority_req;
          unique case (req_type)
            REQ_JOB: begin
              if (rbusy_r && (owner_r == task_id)) begin
                rbusy_nxt          = 1'b0;
                owner_nxt          = '0;
                res.job_terminated = 1'b1;
                res_valid          = 1'b1;
              end else if (fill_r == CNT_W'(QUEUE_DEPTH)) begin
                res.request_dropped = 1'b1;
                res_valid           = 1'b1;
              end else if (fill_r == '0) begin
                mem_req.we         = 1'b1;
                mem_req.waddr      = head_r;
                mem_req.wdata.id   = task_id;
                mem_req.wdata.prio = priority_req;
                fill_nxt           = CNT_W'(1);
                res_valid          = 1'b1;
              end else begin
                // start at the tail and walk toward the head
                cur_nxt       = IDX_W'(fill_r - CNT_W'(1));
                mem_req.raddr = pwq_phys(head_r, IDX_W'(fill_r - CNT_W'(1)));
                state_nxt     = S_WALK;
              end
            end
            REQ_DISPATCH: begin
              if (fill_r == '0) begin
                res.queue_was_empty = 1'b1;
                res_valid           = 1'b1;
              end else begin
                state_nxt = S_POP;
              end
            end
            REQ_DEREG: begin
              if (owner_r == task_id) begin
                rbusy_nxt = 1'b0;
              end
              res_valid = 1'b1;
            end
            default: begin
              res_valid = 1'b1;
            end
          endcase
        end
      end
      S_WALK: begin
        // prefetch the next lower entry; unused once the walk stops
        mem_req.raddr = pwq_phys(head_r, cur_r - IDX_W'(1));
        mem_req.we    = 1'b1;
        mem_req.waddr = pwq_phys(head_r, cur_r + IDX_W'(1));
        if (move) begin
          mem_req.wdata = mem_rdata;
          if (cur_r == '0) begin
            state_nxt = S_LAST;
          end else begin
            cur_nxt = cur_r - IDX_W'(1);
          end
        end else begin
          mem_req.wdata = new_r;
          fill_nxt      = fill_r + CNT_W'(1);
          state_nxt     = S_IDLE;
          res_valid     = 1'b1;
        end
      end
      S_LAST: begin
        // new entry becomes the head
        mem_req.we    = 1'b1;
        mem_req.waddr = head_r;
        mem_req.wdata = new_r;
        fill_nxt      = fill_r + CNT_W'(1);
        state_nxt     = S_IDLE;
        res_valid     = 1'b1;
      end
      S_POP: begin
        owner_nxt         = mem_rdata.id;
        rbusy_nxt         = 1'b1;
        head_nxt          = pwq_phys(head_r, IDX_W'(1));
        fill_nxt          = fill_r - CNT_W'(1);
        res.granted_valid = 1'b1;
        res.granted_id    = mem_rdata.id;
        state_nxt         = S_IDLE;
        res_valid         = 1'b1;
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase

    // status after this step
    res.resource_busy_now = rbusy_nxt;
    res.waiting_count     = WAIT_W'(fill_nxt);
  end

  // Control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      fill_r  <= '0;
      head_r  <= '0;
      rbusy_r <= 1'b0;
      owner_r <= '0;
    end else begin
      state_r <= state_nxt;
      fill_r  <= fill_nxt;
      head_r  <= head_nxt;
      rbusy_r <= rbusy_nxt;
      owner_r <= owner_nxt;
    end
  end

  // Request payload and walk cursor
  always_ff @(posedge clk) begin
    cur_r <= cur_nxt;
    new_r <= new_nxt;
  end

endmodule
